/* hw/rtl/stream_find_replace_unit_macros.svh */
// Assertion macros shared by the stream find-and-replace unit.
// Included by the top level; needs nothing else.
`ifndef STREAM_FIND_REPLACE_UNIT_MACROS_SVH
`define STREAM_FIND_REPLACE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sfr_pkg.sv */
// Shared types, constants and helper functions of the stream find-and-replace unit.
// Used by every module of the block; depends on nothing.
package sfr_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPL_MAX        = 8;
    localparam int JOB_DEPTH       = 2;
    localparam int COUNT_W         = 16;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int LEN_W           = 4;

    localparam logic [63:0]      PATTERN_BYTES_RST  = 64'h0;
    localparam logic [LEN_W-1:0] PATTERN_LEN_RST    = 4'd1;
    localparam logic [63:0]      REPL_BYTES_RST     = 64'h0;
    localparam logic [LEN_W-1:0] REPL_LEN_RST       = 4'd0;
    localparam logic             FOLD_CASE_RST      = 1'b1;
    localparam logic [COUNT_W-1:0] COUNT_SAT        = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES = 3'd0,
        CFG_PATTERN_LEN   = 3'd1,
        CFG_REPL_BYTES    = 3'd2,
        CFG_REPL_LEN      = 3'd3,
        CFG_FOLD_CASE     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_char;
        logic               char_valid;
        logic               last_result;
        logic [COUNT_W-1:0] match_count;
    } out_item_t;

    // One unit of work for the emitter: up to eight bytes to send in order,
    // whether this closes the text, and the match count to report.
    typedef struct packed {
        logic [REPL_MAX*8-1:0] bytes;
        logic [LEN_W-1:0]      byte_count;
        logic                  fin;
        logic [COUNT_W-1:0]    count;
    } job_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && (c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/stream_find_replace_unit.sv */
// Top level of the streaming find-and-replace unit.
// Uses sfr_pkg, sfr_front, sfr_job_fifo, sfr_back and the assertion macro header.
//
// Usage. Text bytes are pushed on the input queue port (push, full, in_item);
// a request is taken on a clock edge with push high and full low. Rewritten
// bytes come out on the result queue port (out_item, empty, pop); the oldest
// result is shown while empty is low and is taken on an edge with pop high.
// Registers are written through cfg_write, cfg_index and cfg_data; the user
// must write them only while the block is idle, and the block itself has no
// check for it. A write to the pattern length drops held bytes. Into an idle
// block, a request that produces output shows its first result through the
// job queue write and then the result register. The emitter sends one
// result per cycle while the receiver keeps taking them; a request makes at
// most one result for a plain byte and up to eight for a replacement or an
// end-of-text flush. The two-entry job queue lets the front end keep taking
// requests while a long replacement drains. When the receiver stalls, the
// result register holds, the queue fills and full rises. Reset empties the
// queue and result slot, clears the window fill and match count, and loads
// the register defaults.
`include "stream_find_replace_unit_macros.svh"

module stream_find_replace_unit #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  sfr_pkg::in_item_t               in_item,
    output logic                            empty,
    input  logic                            pop,
    output sfr_pkg::out_item_t              out_item
);

    logic          accept;
    logic          eot_accept;
    logic          job_push;
    sfr_pkg::job_t job_in;
    sfr_pkg::job_t job_head;
    logic          job_head_valid;
    logic          job_pop;
    logic          fifo_full;

    // Input is taken whenever the job queue has room.
    assign full       = fifo_full;
    assign accept     = push && !fifo_full;
    assign eot_accept = accept && in_item.end_of_text;

    sfr_front #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .accept   (accept),
        .in_item  (in_item),
        .job_push (job_push),
        .job      (job_in)
    );

    sfr_job_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (job_in),
        .full      (fifo_full),
        .pop       (job_pop),
        .head      (job_head),
        .head_valid(job_head_valid)
    );

    sfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (job_head),
        .head_valid(job_head_valid),
        .job_pop   (job_pop),
        .out_item  (out_item),
        .empty     (empty),
        .pop       (pop)
    );

    // Every accepted end-of-text request must leave a job so the text gets closed.
    `SFR_ASSERT_NOW(a_end_makes_job, clk, rst_n, eot_accept, job_push, "end without job")

    // The front end only produces jobs for requests that the queue had room for.
    `SFR_ASSERT_NOW(a_push_has_room, clk, rst_n, job_push, !fifo_full, "push into full queue")

    // The emitter only retires a job that is actually queued.
    `SFR_ASSERT_NOW(a_pop_has_job, clk, rst_n, job_pop, job_head_valid, "pop from empty queue")

    // A queued job that is not retired is still there in the next cycle.
    `SFR_ASSERT_NEXT(a_job_stays, clk, rst_n, job_head_valid && !job_pop, job_head_valid, "lost job")

endmodule

/* hw/rtl/sfr_front.sv */
// Front end: configuration registers, the match window and item classification.
// Uses sfr_pkg; produces jobs for the job queue.
module sfr_front #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               accept,
    input  sfr_pkg::in_item_t                  in_item,
    output logic                               job_push,
    output sfr_pkg::job_t                      job
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam int WIN_W  = PATTERN_MAX * 8;

    logic [63:0]               pattern_reg;
    logic [sfr_pkg::LEN_W-1:0] pattern_len_reg;
    logic [63:0]               repl_reg;
    logic [sfr_pkg::LEN_W-1:0] repl_len_reg;
    logic                      fold_reg;

    logic [WIN_W-1:0]            window_reg, window_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [sfr_pkg::COUNT_W-1:0] match_reg, match_next;

    logic [sfr_pkg::LEN_W-1:0] plen4;
    logic [sfr_pkg::LEN_W-1:0] rlen;
    logic [FILL_W-1:0]         plen;
    logic [FILL_W-1:0]         fill_cur;
    logic [FILL_W-1:0]         fill_add;
    logic [WIN_W-1:0]          win_ins;
    logic                      win_full;
    logic                      hit;
    logic [sfr_pkg::COUNT_W-1:0] count_upd;

    always_comb
    begin
        if (pattern_len_reg == 4'd0)
        begin
            plen4 = 4'd1;
        end
        else if (pattern_len_reg > sfr_pkg::LEN_W'(PATTERN_MAX))
        begin
            plen4 = sfr_pkg::LEN_W'(PATTERN_MAX);
        end
        else
        begin
            plen4 = pattern_len_reg;
        end
        plen = plen4[FILL_W-1:0];
        rlen = (repl_len_reg > 4'd8) ? 4'd8 : repl_len_reg;
    end

    // Place the new byte after the bytes already held and compare the lanes in use.
    always_comb
    begin
        fill_cur = (fill_reg >= plen) ? '0 : fill_reg;
        fill_add = fill_cur + 1'b1;
        win_full = (fill_add == plen);
        win_ins  = window_reg;
        hit      = win_full;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (FILL_W'(i) == fill_cur)
            begin
                win_ins[i*8 +: 8] = in_item.text_char;
            end
        end
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if ((4'(i) < 4'(plen)) &&
                (sfr_pkg::fold_char(win_ins[i*8 +: 8], fold_reg) !=
                 sfr_pkg::fold_char(pattern_reg[i*8 +: 8], fold_reg)))
            begin
                hit = 1'b0;
            end
        end
        count_upd = (hit && (match_reg != sfr_pkg::COUNT_SAT)) ? match_reg + 1'b1 : match_reg;
    end

    always_comb
    begin
        window_next     = window_reg;
        fill_next       = fill_reg;
        match_next      = match_reg;
        job.bytes       = 64'(win_ins);
        job.byte_count  = '0;
        job.fin         = in_item.end_of_text;
        job.count       = count_upd;
        job_push        = 1'b0;
        if (accept)
        begin
            window_next = win_ins;
            if (hit)
            begin
                job.bytes      = repl_reg;
                job.byte_count = rlen;
                fill_next      = '0;
            end
            else if (win_full)
            begin
                if (in_item.end_of_text)
                begin
                    job.byte_count = 4'(plen);
                    fill_next      = '0;
                end
                else
                begin
                    // Emit the oldest byte and slide the window by one.
                    job.byte_count = 4'd1;
                    window_next    = win_ins >> 8;
                    fill_next      = plen - 1'b1;
                end
            end
            else
            begin
                if (in_item.end_of_text)
                begin
                    job.byte_count = 4'(fill_add);
                    fill_next      = '0;
                end
                else
                begin
                    fill_next = fill_add;
                end
            end
            match_next = in_item.end_of_text ? '0 : count_upd;
            job_push   = (job.byte_count != 4'd0) || in_item.end_of_text;
        end
        if (cfg_write && (cfg_index == sfr_pkg::CFG_PATTERN_LEN))
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= sfr_pkg::PATTERN_BYTES_RST;
            pattern_len_reg <= sfr_pkg::PATTERN_LEN_RST;
            repl_reg        <= sfr_pkg::REPL_BYTES_RST;
            repl_len_reg    <= sfr_pkg::REPL_LEN_RST;
            fold_reg        <= sfr_pkg::FOLD_CASE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sfr_pkg::CFG_PATTERN_BYTES: pattern_reg     <= cfg_data;
                sfr_pkg::CFG_PATTERN_LEN:   pattern_len_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::CFG_REPL_BYTES:    repl_reg        <= cfg_data;
                sfr_pkg::CFG_REPL_LEN:      repl_len_reg    <= cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::CFG_FOLD_CASE:     fold_reg        <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            match_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

endmodule

/* hw/rtl/sfr_job_fifo.sv */
// Short queue of jobs between the front end and the emitter.
// Uses sfr_pkg for the job type and depth.
module sfr_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfr_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output sfr_pkg::job_t head,
    output logic          head_valid
);

    localparam int DEPTH = sfr_pkg::JOB_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfr_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hw/rtl/sfr_back.sv */
// Emitter: walks each job one byte per cycle into the registered result slot,
// unless that slot is held. Uses sfr_pkg; takes jobs from the job queue.
module sfr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfr_pkg::job_t         head,
    input  logic                  head_valid,
    output logic                  job_pop,
    output sfr_pkg::out_item_t    out_item,
    output logic                  empty,
    input  logic                  pop
);

    sfr_pkg::out_item_t out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         idx_reg, idx_next;
    logic               emit;
    logic               at_end;

    assign out_item = out_reg;
    assign empty    = !out_valid_reg;
    assign emit     = head_valid && (!out_valid_reg || pop);
    assign at_end   = ({1'b0, idx_reg} == head.byte_count - 1'b1);

    always_comb
    begin
        out_next             = out_reg;
        out_valid_next       = out_valid_reg && !pop;
        idx_next             = idx_reg;
        job_pop              = 1'b0;
        if (emit)
        begin
            out_valid_next       = 1'b1;
            out_next.match_count = head.count;
            if (head.byte_count == 4'd0)
            begin
                // A text that ends with nothing to send gets a bare end marker.
                out_next.out_char    = 8'h00;
                out_next.char_valid  = 1'b0;
                out_next.last_result = 1'b1;
                job_pop              = 1'b1;
            end
            else
            begin
                out_next.out_char    = head.bytes[{idx_reg, 3'b000} +: 8];
                out_next.char_valid  = 1'b1;
                out_next.last_result = head.fin && at_end;
                if (at_end)
                begin
                    job_pop  = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule
